>>> rtl/dipole_orbit_verlet_step_assert.svh
// Assertion macros for the dipole orbit step block
`ifndef DIPOLE_ORBIT_VERLET_STEP_ASSERT_SVH
`define DIPOLE_ORBIT_VERLET_STEP_ASSERT_SVH
`ifndef ASSERT_OFF
`define DOV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DOV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DOV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DOV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/dov_pkg.sv
// ----------------------------------------------------------------------------
// dov_pkg
// Shared types, opcodes and reset constants of the dipole orbit step block.
// ----------------------------------------------------------------------------
package dov_pkg;
    localparam int FRAC_BITS_DEF = 56;
    localparam int W = 64;
    localparam int STEP_W = 57;
    localparam int CFG_IDX_W = 3;

    localparam logic [STEP_W-1:0] STEP_RST = 57'd7205759404;
    localparam logic [W-1:0] GAMMA_RST = 64'hFF80000000000000;
    localparam logic [W-1:0] SR_RST = 64'd18551443757846661;
    localparam logic [W-1:0] SZ_RST = 64'd22675588095013428;

    typedef enum logic [2:0] {
        CFG_STEP = 3'd0,
        CFG_GAMMA = 3'd1,
        CFG_SR = 3'd2,
        CFG_SZ = 3'd3,
        CFG_SV = 3'd4,
        CFG_SY = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_HYP
    } op_t;

    // register file slots
    typedef enum logic [4:0] {
        S_RP, S_ZP, S_RV, S_ZV, S_H, S_HH, S_G, S_ONE,
        S_G2, S_CR, S_CZ, S_R, S_R2, S_R3, S_R5, S_RR,
        S_RZ, S_T1, S_T2, S_T3, S_FA, S_FB, S_AR0, S_AZ0,
        S_AR1, S_AZ1, S_RN, S_ZN, S_VN, S_YN, S_ZERO
    } slot_t;

    typedef struct packed {
        logic start;
        op_t op;
        slot_t a;
        slot_t b;
        slot_t d;
    } cmd_t;

    typedef struct packed {
        logic done;
    } sts_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_ISSUE, ST_WAIT, ST_COMMIT, ST_OUT
    } state_t;

    typedef struct packed {
        op_t op;
        slot_t a;
        slot_t b;
        slot_t d;
    } uop_t;

    localparam int NUOP = 48;
    localparam int UPC_W = 6;

    function automatic uop_t uop_at(logic [UPC_W-1:0] pc);
        uop_t u;
        u = '{OP_ADD, S_RP, S_RP, S_RP};
        unique case (pc)
            6'd0: u = '{OP_ADD, S_G, S_G, S_G2};
            6'd1: u = '{OP_ADD, S_RP, S_ZERO, S_CR};
            6'd2: u = '{OP_ADD, S_ZP, S_ZERO, S_CZ};
            6'd3: u = '{OP_HYP, S_RP, S_ZP, S_R};
            // shared acc sequence (pc 4..24) on CR, CZ
            6'd4: u = '{OP_HYP, S_CR, S_CZ, S_R};
            6'd5: u = '{OP_MUL, S_R, S_R, S_R2};
            6'd6: u = '{OP_MUL, S_R2, S_R, S_R3};
            6'd7: u = '{OP_MUL, S_R3, S_R2, S_R5};
            6'd8: u = '{OP_MUL, S_CR, S_CR, S_RR};
            6'd9: u = '{OP_MUL, S_CR, S_CZ, S_RZ};
            6'd10: u = '{OP_DIV, S_G2, S_CR, S_T1};
            6'd11: u = '{OP_DIV, S_CR, S_R3, S_T2};
            6'd12: u = '{OP_ADD, S_T1, S_T2, S_FA};
            6'd13: u = '{OP_DIV, S_G2, S_RR, S_T1};
            6'd14: u = '{OP_ADD, S_RR, S_RR, S_T2};
            6'd15: u = '{OP_ADD, S_T2, S_RR, S_T2};
            6'd16: u = '{OP_DIV, S_T2, S_R5, S_T2};
            6'd17: u = '{OP_ADD, S_T1, S_T2, S_T1};
            6'd18: u = '{OP_DIV, S_ONE, S_R3, S_T2};
            6'd19: u = '{OP_SUB, S_T1, S_T2, S_FB};
            6'd20: u = '{OP_MUL, S_FA, S_FB, S_T3};
            6'd21: u = '{OP_ADD, S_RZ, S_RZ, S_T1};
            6'd22: u = '{OP_ADD, S_T1, S_RZ, S_T1};
            6'd23: u = '{OP_DIV, S_T1, S_R5, S_T1};
            6'd24: u = '{OP_MUL, S_T1, S_FA, S_T2};
            // first pass tail
            6'd25: u = '{OP_ADD, S_T3, S_ZERO, S_AR0};
            6'd26: u = '{OP_ADD, S_T2, S_ZERO, S_AZ0};
            6'd27: u = '{OP_MUL, S_AR0, S_HH, S_T1};
            6'd28: u = '{OP_ADD, S_T1, S_RV, S_T1};
            6'd29: u = '{OP_MUL, S_T1, S_H, S_T1};
            6'd30: u = '{OP_ADD, S_RP, S_T1, S_RN};
            6'd31: u = '{OP_MUL, S_AZ0, S_HH, S_T1};
            6'd32: u = '{OP_ADD, S_T1, S_ZV, S_T1};
            6'd33: u = '{OP_MUL, S_T1, S_H, S_T1};
            6'd34: u = '{OP_ADD, S_ZP, S_T1, S_ZN};
            6'd35: u = '{OP_ADD, S_RN, S_ZERO, S_CR};
            6'd36: u = '{OP_ADD, S_ZN, S_ZERO, S_CZ};
            // second pass tail
            6'd37: u = '{OP_ADD, S_T3, S_ZERO, S_AR1};
            6'd38: u = '{OP_ADD, S_T2, S_ZERO, S_AZ1};
            6'd39: u = '{OP_MUL, S_AR1, S_HH, S_T1};
            6'd40: u = '{OP_MUL, S_HH, S_AR0, S_T2};
            6'd41: u = '{OP_ADD, S_T1, S_T2, S_T1};
            6'd42: u = '{OP_ADD, S_T1, S_RV, S_VN};
            6'd43: u = '{OP_MUL, S_AZ1, S_HH, S_T1};
            6'd44: u = '{OP_MUL, S_HH, S_AZ0, S_T2};
            6'd45: u = '{OP_ADD, S_T1, S_T2, S_T1};
            6'd46: u = '{OP_ADD, S_T1, S_ZV, S_YN};
            default: u = '{OP_ADD, S_RP, S_RP, S_RP};
        endcase
        return u;
    endfunction
endpackage

>>> rtl/dov_ctrl.sv
// ----------------------------------------------------------------------------
// dov_ctrl
// Sequencer: steps through the operation list, one datapath op at a time.
// ----------------------------------------------------------------------------
module dov_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_go,
    input  logic out_free,
    input  dov_pkg::sts_t sts,
    output dov_pkg::cmd_t cmd,
    output logic load,
    output logic busy,
    output logic out_set
);
    import dov_pkg::*;

    state_t state_reg, state_next;
    logic [UPC_W-1:0] pc_reg, pc_next;
    logic pass_reg, pass_next;
    uop_t u;

    // shadow copies to skip op 3 (unused hypot) and make the CR/CZ copies
    // Pass 0: 0,1,2,4..26,27..36 then jump to 4 with pass 1; pass 1 exits at 24 to 37.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            pass_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            pass_reg <= pass_next;
        end
    end

    always_comb
    begin
        u = uop_at(pc_reg);
        state_next = state_reg;
        pc_next = pc_reg;
        pass_next = pass_reg;
        cmd = '{1'b0, u.op, u.a, u.b, u.d};
        load = 1'b0;
        busy = (state_reg != ST_IDLE);
        out_set = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_go)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                load = 1'b1;
                pc_next = '0;
                pass_next = 1'b0;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                cmd.start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.done)
                begin
                    state_next = ST_ISSUE;
                    priority if (pc_reg == UPC_W'(2))
                        pc_next = UPC_W'(4);
                    else if (pc_reg == UPC_W'(24) && pass_reg)
                        pc_next = UPC_W'(37);
                    else if (pc_reg == UPC_W'(36))
                    begin
                        pc_next = UPC_W'(4);
                        pass_next = 1'b1;
                    end
                    else if (pc_reg == UPC_W'(NUOP - 2))
                        state_next = ST_OUT;
                    else
                        pc_next = pc_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_set = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

>>> rtl/dov_dp.sv
// ----------------------------------------------------------------------------
// dov_dp
// Datapath: register file, saturating add/sub, multiplier of four 32x32
// passes, bit-serial divider and square root.
// ----------------------------------------------------------------------------
module dov_dp #(
    parameter int FRAC_BITS = dov_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  dov_pkg::cmd_t cmd,
    input  logic load,
    input  logic restart,
    input  logic [dov_pkg::STEP_W-1:0] step_size,
    input  logic [dov_pkg::W-1:0] gamma,
    input  logic [dov_pkg::W-1:0] sr,
    input  logic [dov_pkg::W-1:0] sz,
    input  logic [dov_pkg::W-1:0] sv,
    input  logic [dov_pkg::W-1:0] sy,
    input  logic commit,
    output dov_pkg::sts_t sts,
    output logic [dov_pkg::W-1:0] rn,
    output logic [dov_pkg::W-1:0] zn,
    output logic [dov_pkg::W-1:0] vn,
    output logic [dov_pkg::W-1:0] yn,
    output logic flt
);
    import dov_pkg::*;

    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
    localparam int NSLOT = 32;

    logic [W-1:0] rf_reg [NSLOT];
    logic flt_reg, flt_next;
    logic done_reg;
    logic [W-1:0] a, b;
    op_t op_reg;
    slot_t d_reg;
    logic busy_reg;
    logic [7:0] cnt_reg;
    logic neg_reg;
    // multiply / shared wide accumulator
    logic [127:0] acc_reg;
    logic [W-1:0] ma_reg, mb_reg;
    // divider
    logic [127:0] num_reg;
    logic [W-1:0] rem_reg;
    // sqrt
    logic [127:0] n_reg;
    logic [129:0] srem_reg;
    logic [W-1:0] root_reg;
    logic [W-1:0] res;
    logic wr;

    assign a = rf_reg[cmd.a];
    assign b = rf_reg[cmd.b];

    function automatic logic [W-1:0] mg(input logic [W-1:0] x);
        return x[W-1] ? (W'(0) - x) : x;
    endfunction

    function automatic logic [W:0] sat(input logic neg, input logic [127:0] m);
        logic [W-1:0] lim;
        lim = neg ? MINN : MAXP;
        if (m[127:W] != '0 || m[W-1:0] > lim)
            return {1'b1, neg ? MINN : MAXP};
        return {1'b0, neg ? (W'(0) - m[W-1:0]) : m[W-1:0]};
    endfunction

    logic [W-1:0] sum, dif;
    logic ovs, ovd;
    assign sum = a + b;
    assign dif = a - b;
    assign ovs = (a[W-1] == b[W-1]) && (sum[W-1] != a[W-1]);
    assign ovd = (a[W-1] != b[W-1]) && (dif[W-1] != a[W-1]);

    logic [W:0] sm;
    logic [W:0] sq;
    logic [127:0] mshift;
    logic [W:0] rs;
    logic [129:0] st;
    logic [129:0] sr2;
    logic [31:0] pa, pb;
    logic [63:0] pp;

    always_comb
    begin
        rs = {rem_reg, num_reg[127]};
        sr2 = {srem_reg[127:0], n_reg[127:126]};
        st = sr2 - {64'd0, root_reg, 2'b01};
        pa = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        pb = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp = pa * pb;
        mshift = acc_reg >> FRAC_BITS;
        sm = sat(neg_reg, mshift);
        sq = sat(neg_reg, acc_reg);
    end

    logic [W-1:0] dvs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            flt_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            flt_reg <= flt_next;
            done_reg <= wr;
            if (cmd.start)
            begin
                busy_reg <= (cmd.op != OP_ADD) && (cmd.op != OP_SUB);
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (wr)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        res = '0;
        wr = 1'b0;
        flt_next = flt_reg;
        if (load)
            flt_next = 1'b0;
        if (cmd.start && cmd.op == OP_ADD)
        begin
            wr = 1'b1;
            res = ovs ? (a[W-1] ? MINN : MAXP) : sum;
            flt_next = flt_reg | ovs;
        end
        else if (cmd.start && cmd.op == OP_SUB)
        begin
            wr = 1'b1;
            res = ovd ? (a[W-1] ? MINN : MAXP) : dif;
            flt_next = flt_reg | ovd;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (cnt_reg == 8'd4)
                    begin
                        wr = 1'b1;
                        res = sm[W-1:0];
                        flt_next = flt_reg | sm[W];
                    end
                end
                OP_DIV:
                begin
                    if (cnt_reg == 8'd0 && dvs_reg == '0)
                    begin
                        wr = 1'b1;
                        res = neg_reg ? MINN : MAXP;
                        flt_next = 1'b1;
                    end
                    else if (cnt_reg == 8'd129)
                    begin
                        wr = 1'b1;
                        res = sq[W-1:0];
                        flt_next = flt_reg | sq[W];
                    end
                end
                OP_HYP:
                begin
                    if (cnt_reg == 8'd74)
                    begin
                        wr = 1'b1;
                        res = root_reg[W-1] ? MAXP : root_reg;
                        flt_next = flt_reg | root_reg[W-1];
                    end
                end
                default: wr = 1'b0;
            endcase
        end
    end

    assign sts.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
                rf_reg[i] <= '0;
            op_reg <= OP_ADD;
            d_reg <= S_RP;
            neg_reg <= 1'b0;
            ma_reg <= '0;
            mb_reg <= '0;
            acc_reg <= '0;
            dvs_reg <= '0;
            num_reg <= '0;
            rem_reg <= '0;
            n_reg <= '0;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                if (restart)
                begin
                    rf_reg[S_RP] <= sr;
                    rf_reg[S_ZP] <= sz;
                    rf_reg[S_RV] <= sv;
                    rf_reg[S_ZV] <= sy;
                end
                rf_reg[S_H] <= W'(step_size);
                rf_reg[S_HH] <= W'(step_size >> 1);
                rf_reg[S_G] <= gamma;
                rf_reg[S_ONE] <= ONE;
                rf_reg[S_ZERO] <= '0;
            end
            if (commit)
            begin
                rf_reg[S_RP] <= rf_reg[S_RN];
                rf_reg[S_ZP] <= rf_reg[S_ZN];
                rf_reg[S_RV] <= rf_reg[S_VN];
                rf_reg[S_ZV] <= rf_reg[S_YN];
            end
            if (cmd.start)
            begin
                op_reg <= cmd.op;
                d_reg <= cmd.d;
                neg_reg <= a[W-1] ^ b[W-1];
                ma_reg <= mg(a);
                mb_reg <= (cmd.op == OP_HYP) ? mg(a) : mg(b);
                acc_reg <= '0;
                dvs_reg <= b;
                num_reg <= {64'd0, mg(a)} << FRAC_BITS;
                rem_reg <= '0;
                n_reg <= '0;
                srem_reg <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                unique case (op_reg)
                    OP_MUL:
                    begin
                        if (cnt_reg < 8'd4)
                            acc_reg <= acc_reg
                                + (128'(pp) << (32 * (cnt_reg[1] + cnt_reg[0])));
                        else
                            acc_reg <= acc_reg;
                    end
                    OP_DIV:
                    begin
                        if (cnt_reg < 8'd128)
                        begin
                            num_reg <= num_reg << 1;
                            if (rs >= {1'b0, mg(dvs_reg)})
                            begin
                                rem_reg <= W'(rs - {1'b0, mg(dvs_reg)});
                                acc_reg <= {acc_reg[126:0], 1'b1};
                            end
                            else
                            begin
                                rem_reg <= rs[W-1:0];
                                acc_reg <= {acc_reg[126:0], 1'b0};
                            end
                        end
                    end
                    OP_HYP:
                    begin
                        // 0..3: square a, 5..8: square b, 10..73: one root bit each
                        if (cnt_reg < 8'd4 || (cnt_reg > 8'd4 && cnt_reg < 8'd9))
                            acc_reg <= acc_reg
                                + (128'(pp) << (32 * (cnt_reg[1] + cnt_reg[0])));
                        else if (cnt_reg == 8'd4)
                        begin
                            ma_reg <= mg(dvs_reg);
                            mb_reg <= mg(dvs_reg);
                        end
                        else if (cnt_reg == 8'd9)
                            n_reg <= acc_reg;
                        else if (cnt_reg < 8'd74)
                        begin
                            if (!st[129])
                            begin
                                srem_reg <= st;
                                root_reg <= {root_reg[W-2:0], 1'b1};
                            end
                            else
                            begin
                                srem_reg <= sr2;
                                root_reg <= {root_reg[W-2:0], 1'b0};
                            end
                            n_reg <= n_reg << 2;
                        end
                    end
                    default: acc_reg <= acc_reg;
                endcase
            end
            if (wr)
                rf_reg[cmd.start ? cmd.d : d_reg] <= res;
        end
    end

    assign rn = rf_reg[S_RN];
    assign zn = rf_reg[S_ZN];
    assign vn = rf_reg[S_VN];
    assign yn = rf_reg[S_YN];
    assign flt = flt_reg;
endmodule

>>> rtl/dipole_orbit_verlet_step.sv
// ----------------------------------------------------------------------------
// dipole_orbit_verlet_step
// Velocity Verlet step of the Stormer dipole problem in signed fixed point.
// ----------------------------------------------------------------------------
// One item in, one result out. A step runs two acceleration evaluations,
// each with a root and six bit-serial divisions, plus multiplies and adds,
// run one after another on a shared datapath; the radix-2 divider dominates
// the step time. A division by zero finishes early, so degenerate orbits run
// shorter. A new item is taken once the previous result has moved into the
// output register.
module dipole_orbit_verlet_step #(
    parameter int FRAC_BITS = dov_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic restart,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [63:0] new_radial_pos,
    output logic signed [63:0] new_axial_pos,
    output logic signed [63:0] new_radial_vel,
    output logic signed [63:0] new_axial_vel,
    output logic fault,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [dov_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data
);
    import dov_pkg::*;
`include "dipole_orbit_verlet_step_assert.svh"

    logic [STEP_W-1:0] step_reg;
    logic [W-1:0] gamma_reg, sr_reg, sz_reg, sv_reg, sy_reg;
    logic restart_reg;
    cmd_t cmd;
    sts_t sts;
    logic load, busy, out_set, flt;
    logic [W-1:0] rn, zn, vn, yn;
    logic out_valid_reg;

    assign cfg_ready = 1'b1;
    assign in_stall = busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RST;
            gamma_reg <= GAMMA_RST;
            sr_reg <= SR_RST;
            sz_reg <= SZ_RST;
            sv_reg <= '0;
            sy_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_STEP: step_reg <= cfg_data[STEP_W-1:0];
                    CFG_GAMMA: gamma_reg <= cfg_data;
                    CFG_SR: sr_reg <= cfg_data;
                    CFG_SZ: sz_reg <= cfg_data;
                    CFG_SV: sv_reg <= cfg_data;
                    CFG_SY: sy_reg <= cfg_data;
                    default: step_reg <= step_reg;
                endcase
            end
            if (out_set)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !busy)
            restart_reg <= restart;
        if (out_set)
        begin
            new_radial_pos <= rn;
            new_axial_pos <= zn;
            new_radial_vel <= vn;
            new_axial_vel <= yn;
            fault <= flt;
        end
    end

    assign out_valid = out_valid_reg;

    dov_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_go(in_valid), .out_free(!out_valid_reg || !out_stall),
        .sts(sts), .cmd(cmd), .load(load), .busy(busy), .out_set(out_set)
    );

    dov_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .load(load), .restart(restart_reg),
        .step_size(step_reg), .gamma(gamma_reg), .sr(sr_reg), .sz(sz_reg), .sv(sv_reg),
        .sy(sy_reg), .commit(out_set), .sts(sts), .rn(rn), .zn(zn), .vn(vn), .yn(yn),
        .flt(flt)
    );

    `DOV_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `DOV_ASSERT_IMP(a_no_take_busy, clk, rst_n, out_set, busy)
    `DOV_ASSERT_NXT(a_load_issue, clk, rst_n, load, busy && !out_set)
endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dipole orbit Verlet step. A fixed-point
// predictor tracks the orbit state and the register file. A directed table
// covers reset, zero radius, saturation and ignored register writes, and
// random phases follow with register changes while the block is idle. Both
// channels idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
    import dov_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam int RAND_ITEMS = 730;
    localparam logic [2:0] IDX_UNUSED_LO = 3'd6;
    localparam logic [2:0] IDX_UNUSED_HI = 3'd7;
    localparam logic signed [63:0] FX_MAX = 64'sh7FFFFFFFFFFFFFFF;
    localparam logic signed [63:0] FX_MIN = 64'sh8000000000000000;
    localparam logic signed [63:0] FX_ONE = 64'sh0100000000000000;

    typedef logic signed [63:0] fx_t;

    typedef struct {
        fx_t rp;
        fx_t zp;
        fx_t rv;
        fx_t zv;
        bit  flt;
    } orbit_t;

    typedef struct {
        bit          wr;
        logic [2:0]  idx;
        logic [63:0] data;
        bit          go;
        bit          rs;
        bit          chk;
        orbit_t      ev;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic restart = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [63:0] new_radial_pos;
    logic signed [63:0] new_axial_pos;
    logic signed [63:0] new_radial_vel;
    logic signed [63:0] new_axial_vel;
    logic fault;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // predictor registers and orbit state
    logic [STEP_W-1:0] m_step;
    fx_t m_gamma, m_sr, m_sz, m_sv, m_sy;
    fx_t o_rp, o_zp, o_rv, o_zv;
    bit  ovf;

    orbit_t orbit_q[$];
    dir_row_t dir_q[$];
    int  fails = 0;
    longint cycles = 0;
    bit  quiet = 1'b0;
    int  stall_left = 0;

    dipole_orbit_verlet_step dut (.*);

    always #2 clk = ~clk;

    function automatic logic [63:0] mag(fx_t a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic fx_t sat_sign(bit neg, logic [127:0] m);
        if (m[127:64] != 0 || m[63:0] > (neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF))
        begin
            ovf = 1'b1;
            return neg ? FX_MIN : FX_MAX;
        end
        return neg ? fx_t'(-m[63:0]) : fx_t'(m[63:0]);
    endfunction

    function automatic fx_t fx_add(fx_t a, fx_t b);
        fx_t r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
        begin
            ovf = 1'b1;
            return a[63] ? FX_MIN : FX_MAX;
        end
        return r;
    endfunction

    function automatic fx_t fx_sub(fx_t a, fx_t b);
        fx_t r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63])
        begin
            ovf = 1'b1;
            return a[63] ? FX_MIN : FX_MAX;
        end
        return r;
    endfunction

    function automatic fx_t fx_mul(fx_t a, fx_t b);
        logic [127:0] p;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        return sat_sign(a[63] ^ b[63], p >> FB);
    endfunction

    function automatic fx_t fx_div(fx_t a, fx_t b);
        logic [127:0] n;
        if (b == 0)
        begin
            ovf = 1'b1;
            return a[63] ? FX_MIN : FX_MAX;
        end
        n = {64'd0, mag(a)} << FB;
        return sat_sign(a[63] ^ b[63], n / {64'd0, mag(b)});
    endfunction

    function automatic fx_t fx_hypot(fx_t a, fx_t b);
        logic [127:0] n;
        logic [63:0] res, c;
        n = {64'd0, mag(a)} * {64'd0, mag(a)} + {64'd0, mag(b)} * {64'd0, mag(b)};
        res = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = res | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= n)
                res = c;
        end
        if (res[63])
        begin
            ovf = 1'b1;
            return FX_MAX;
        end
        return fx_t'(res);
    endfunction

    task automatic dipole_accel(input fx_t rp, input fx_t zp, output fx_t ar, output fx_t az);
        fx_t g2, r, r2, r3, r5, rr, rz, fa, fb;
        g2 = fx_add(m_gamma, m_gamma);
        r = fx_hypot(rp, zp);
        r2 = fx_mul(r, r);
        r3 = fx_mul(r2, r);
        r5 = fx_mul(r3, r2);
        rr = fx_mul(rp, rp);
        rz = fx_mul(rp, zp);
        fa = fx_add(fx_div(g2, rp), fx_div(rp, r3));
        fb = fx_sub(fx_add(fx_div(g2, rr), fx_div(fx_add(fx_add(rr, rr), rr), r5)),
                    fx_div(FX_ONE, r3));
        ar = fx_mul(fa, fb);
        az = fx_mul(fx_div(fx_add(fx_add(rz, rz), rz), r5), fa);
    endtask

    task automatic verlet_advance(input bit rs, output orbit_t res);
        fx_t h, hh, ar0, az0, ar1, az1;
        h = fx_t'({7'd0, m_step});
        hh = fx_t'({8'd0, m_step[STEP_W-1:1]});
        ovf = 1'b0;
        if (rs)
        begin
            o_rp = m_sr;
            o_zp = m_sz;
            o_rv = m_sv;
            o_zv = m_sy;
        end
        dipole_accel(o_rp, o_zp, ar0, az0);
        res.rp = fx_add(o_rp, fx_mul(fx_add(fx_mul(ar0, hh), o_rv), h));
        res.zp = fx_add(o_zp, fx_mul(fx_add(fx_mul(az0, hh), o_zv), h));
        dipole_accel(res.rp, res.zp, ar1, az1);
        res.rv = fx_add(fx_add(fx_mul(ar1, hh), fx_mul(hh, ar0)), o_rv);
        res.zv = fx_add(fx_add(fx_mul(az1, hh), fx_mul(hh, az0)), o_zv);
        res.flt = ovf;
        o_rp = res.rp;
        o_zp = res.zp;
        o_rv = res.rv;
        o_zv = res.zv;
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_STEP:  m_step = data[STEP_W-1:0];
            CFG_GAMMA: m_gamma = data;
            CFG_SR:    m_sr = data;
            CFG_SZ:    m_sz = data;
            CFG_SV:    m_sv = data;
            CFG_SY:    m_sy = data;
            default: ;
        endcase
    endtask

    task automatic reg_close();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (orbit_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // valid stays high between back-to-back items; only a gap lowers it
    task automatic send_step(input bit rs, input bit chk, input orbit_t ev);
        orbit_t pred;
        in_valid <= 1'b1;
        restart <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        verlet_advance(rs, pred);
        orbit_q.push_back(chk ? ev : pred);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            restart <= $urandom_range(0, 1);
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] rnd_word(int kind);
        logic [63:0] w;
        w = {$urandom, $urandom};
        case (kind)
            0: return w;
            1: return $urandom_range(0, 1) ? FX_MAX : FX_MIN;
            2: return 64'(0);
            default: return 64'(signed'(w) >>> $urandom_range(6, 12));
        endcase
    endfunction

    task automatic random_setup();
        int k;
        k = $urandom_range(0, 9);
        case ($urandom_range(0, 5))
            0: reg_write(CFG_STEP, {$urandom, $urandom});
            1: reg_write(CFG_STEP, 64'd1 << 56);
            2: reg_write(CFG_STEP, 64'd0);
            default: reg_write(CFG_STEP, 64'({$urandom, $urandom} >> $urandom_range(20, 40)));
        endcase
        reg_write(CFG_GAMMA, rnd_word(k < 2 ? k : 3));
        reg_write(CFG_SR, rnd_word(k == 2 ? 2 : (k < 2 ? k : 3)));
        reg_write(CFG_SZ, rnd_word(k < 3 ? k : 3));
        reg_write(CFG_SV, rnd_word(k < 3 ? k : 4 + $urandom_range(0, 3)) >>> 4);
        reg_write(CFG_SY, rnd_word(k < 3 ? k : 4) >>> 4);
        if ($urandom_range(0, 3) == 0)
            reg_write($urandom_range(0, 1) ? IDX_UNUSED_LO : IDX_UNUSED_HI, {$urandom, $urandom});
        reg_close();
    endtask

    // result check and receiver stall bursts
    always @(posedge clk)
    begin
        orbit_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (orbit_q.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected result rp=%h", $time, new_radial_pos);
            end
            else
            begin
                e = orbit_q.pop_front();
                if (new_radial_pos !== e.rp)
                begin
                    fails++;
                    $display("%0t: new_radial_pos exp %h got %h", $time, e.rp, new_radial_pos);
                end
                if (new_axial_pos !== e.zp)
                begin
                    fails++;
                    $display("%0t: new_axial_pos exp %h got %h", $time, e.zp, new_axial_pos);
                end
                if (new_radial_vel !== e.rv)
                begin
                    fails++;
                    $display("%0t: new_radial_vel exp %h got %h", $time, e.rv, new_radial_vel);
                end
                if (new_axial_vel !== e.zv)
                begin
                    fails++;
                    $display("%0t: new_axial_vel exp %h got %h", $time, e.zv, new_axial_vel);
                end
                if (fault !== e.flt)
                begin
                    fails++;
                    $display("%0t: fault exp %b got %b", $time, e.flt, fault);
                end
            end
        end
        if (quiet)
            out_stall <= 1'b0;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_left <= $urandom_range(1, 17);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        orbit_t zero_orbit;
        orbit_t none;
        dir_row_t row;
        int n;
        zero_orbit = '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b1};
        none = '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b0};
        m_step = STEP_RST;
        m_gamma = GAMMA_RST;
        m_sr = SR_RST;
        m_sz = SZ_RST;
        m_sv = 0;
        m_sy = 0;
        o_rp = 0;
        o_zp = 0;
        o_rv = 0;
        o_zv = 0;

        // zero state after reset: every divisor is zero
        dir_q.push_back('{0, CFG_STEP, 64'd0, 1, 0, 1, zero_orbit});
        dir_q.push_back('{0, CFG_STEP, 64'd0, 1, 1, 0, none});
        dir_q.push_back('{0, CFG_STEP, 64'd0, 1, 0, 0, none});
        dir_q.push_back('{1, IDX_UNUSED_LO, '1, 1, 0, 0, none});
        dir_q.push_back('{1, IDX_UNUSED_HI, '1, 1, 0, 0, none});
        dir_q.push_back('{1, CFG_SR, 64'd0, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_SZ, 64'd0, 1, 1, 1, zero_orbit});
        dir_q.push_back('{1, CFG_SR, FX_MAX, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_SZ, FX_MIN, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_SR, FX_MIN, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_STEP, 64'd1 << 56, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_SR, SR_RST, 0, 0, 0, none});
        dir_q.push_back('{1, CFG_SZ, SZ_RST, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_GAMMA, FX_MAX, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_GAMMA, FX_MIN, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_SV, FX_MAX, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_SY, FX_MIN, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_STEP, '1, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_STEP, 64'd0, 1, 1, 0, none});
        dir_q.push_back('{1, CFG_GAMMA, GAMMA_RST, 0, 0, 0, none});
        dir_q.push_back('{1, CFG_SV, 64'd0, 0, 0, 0, none});
        dir_q.push_back('{1, CFG_SY, 64'd0, 0, 0, 0, none});
        dir_q.push_back('{1, CFG_STEP, STEP_RST, 1, 1, 0, none});
        dir_q.push_back('{0, CFG_STEP, 64'd0, 1, 0, 0, none});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_q[i])
        begin
            row = dir_q[i];
            if (row.wr)
            begin
                drain();
                reg_write(row.idx, row.data);
                reg_close();
            end
            if (row.go)
                send_step(row.rs, row.chk, row.ev);
        end

        n = 0;
        while (n < RAND_ITEMS)
        begin
            drain();
            if (n > RAND_ITEMS - 100)
                quiet = 1'b1;
            random_setup();
            send_step(1'b1, 1'b0, none);
            n++;
            repeat ($urandom_range(10, 60))
            begin
                // mostly continue the orbit, sometimes restart it
                send_step($urandom_range(0, 9) == 0, 1'b0, none);
                n++;
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/dov_pkg.sv
rtl/dov_ctrl.sv
rtl/dov_dp.sv
rtl/dipole_orbit_verlet_step.sv
sim/testbench.sv
